// ----- sv/playback_time_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// playback_time_sequencer_assert.svh
// assertion macros used by the playback time sequencer
// ----------------------------------------------------------------------------
`ifndef PLAYBACK_TIME_SEQUENCER_ASSERT_SVH
`define PLAYBACK_TIME_SEQUENCER_ASSERT_SVH

// implication checked at every clock edge outside reset
`define PTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// a condition that must hold in the cycle after a trigger
`define PTS_ASSERT_NEXT(lbl, clk, rstn, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) else $error(msg);

`endif

// ----- sv/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// types, codes and helpers of the playback time sequencer
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int DVD_W = 42;   // widest dividend: scaled delay total
    localparam int DSR_W = 32;   // divisor: delay length
    localparam int A_W   = 33;   // multiplier operand a
    localparam int B_W   = 24;   // multiplier operand b (scale)
    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(DVD_W + 1);
    // ceil(2^35 / 15): x / 15 for any 32-bit x
    localparam logic [31:0] DIV15_MAGIC = 32'h88888889;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_PLAY   = 3'd1,
        OP_PAUSE  = 3'd2,
        OP_STOP   = 3'd3,
        OP_SEEK   = 3'd4,
        OP_JEND   = 3'd5,
        OP_JBEGIN = 3'd6,
        OP_NONE   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_LENGTH = 3'd1,
        REG_LSTART = 3'd2,
        REG_LEND   = 3'd3,
        REG_SCALE  = 3'd4,
        REG_SDLEN  = 3'd5,
        REG_LDLEN  = 3'd6,
        REG_UNUSED = 3'd7
    } reg_idx_t;

    localparam logic [1:0] RUN_STOPPED = 2'd0;
    localparam logic [1:0] RUN_PLAYING = 2'd1;
    localparam logic [1:0] RUN_PAUSED  = 2'd2;

    localparam int F_LINEAR   = 0;
    localparam int F_PINGPONG = 1;
    localparam int F_LOOP     = 2;
    localparam int F_RANGE    = 3;
    localparam int F_SDELAY   = 4;
    localparam int F_LDELAY   = 5;
    localparam int F_TRIG     = 6;
    localparam int F_REVERSE  = 7;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DSR_W-1:0] remainder;
    } div_rsp_t;

    // product times 30, then drop the 20 fraction bits of the seconds
    function automatic logic [41:0] scale30(input logic [P_W-1:0] p);
        logic [61:0] x;
        x = {p, 5'b0} - {4'b0, p, 1'b0};
        return x[61:20];
    endfunction

    // floor(s / 30) as floor(floor(s / 2) / 15) by reciprocal multiply
    function automatic logic [31:0] div30(input logic [32:0] s);
        logic [63:0] p;
        p = 64'(s[32:1]) * 64'(DIV15_MAGIC);
        return 32'(p[63:35]);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [43:0] v);
        logic [31:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > 44'sh0FFFFFFFF) begin
            r = '1;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/pts_mul.sv -----
// ----------------------------------------------------------------------------
// pts_mul
// shared registered multiplier, operand times the effective scale
// ----------------------------------------------------------------------------
module pts_mul (
    input  logic                      aclk,
    input  logic [pts_pkg::A_W-1:0]   a,
    input  logic [pts_pkg::B_W-1:0]   b,
    output logic [pts_pkg::P_W-1:0]   p
);

    logic [pts_pkg::P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= pts_pkg::P_W'(a) * pts_pkg::P_W'(b);
    end

    assign p = p_reg;

endmodule

// ----- sv/pts_div.sv -----
// ----------------------------------------------------------------------------
// pts_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pts_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  pts_pkg::div_req_t req,
    output pts_pkg::div_rsp_t rsp
);

    localparam int DW = pts_pkg::DVD_W;
    localparam int SW = pts_pkg::DSR_W;

    logic [DW-1:0]                 dvd_reg;
    logic [SW-1:0]                 rem_reg;
    logic [SW-1:0]                 dsr_reg;
    logic [pts_pkg::CNT_W-1:0]     cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [SW:0]                   trial;
    logic                          fits;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= pts_pkg::CNT_W'(DW);
                dvd_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= fits ? SW'(trial - {1'b0, dsr_reg}) : trial[SW-1:0];
                dvd_reg <= {dvd_reg[DW-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == pts_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- sv/playback_time_sequencer.sv -----
// ----------------------------------------------------------------------------
// playback_time_sequencer
// Q16.16 playback position counter with linear, ping-pong and delay modes
// ----------------------------------------------------------------------------
//  channel   ports        fields (lowest bit up)
//  input     s_axis_*     tdata: step_seconds[23:0], seek_time[55:24]; tuser: op
//  result    m_axis_*     tdata: position, done_res, run_state, going_backward
//  config    cfg_*        index 0..6, data up to 32 bits
//
//  play, pause, stop, jumps and op 7 go straight to the result stage; seek adds
//  a multiply and a reflect step. tick runs the shared multiplier, then a delay
//  or update step when playing; a delay whose total overshoots its length adds a
//  divider pass. the elapsed delay over 30 is a reciprocal multiply done in
//  the delay step. reset is synchronous and needs no clearing pass.
//  a waiting result holds the last stage; the input is taken only when idle.
// ----------------------------------------------------------------------------
module playback_time_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // step_seconds[23:0], seek_time[55:24]
    input  logic [2:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // position[31:0], done_res[32],
                                        // run_state[34:33], going_backward[35]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_M_BEG, ST_M_END, ST_M_SD, ST_M_LD, ST_M_STEP, ST_M_SUM,
        ST_DLY, ST_DMOD, ST_UPD, ST_SK_MUL, ST_SK, ST_FIN
    } state_t;

    state_t state_reg;

    logic [7:0]  mode_reg;
    logic [31:0] length_reg, sdlen_reg, ldlen_reg;
    logic [15:0] lstart_reg, lend_reg;
    logic [23:0] scale_reg;

    logic [31:0] pos_reg, sde_reg, lde_reg;
    logic [1:0]  run_reg;
    logic        dir_reg;

    logic [23:0] step_reg;
    logic [31:0] seek_reg;
    logic [40:0] beg_reg, end_reg;
    logic [41:0] sds_reg, lds_reg, s_reg;
    logic [32:0] sum_reg;
    logic        sel_ld_reg;
    logic        done_reg;
    logic signed [43:0] posw_reg;

    logic        m_valid_reg;
    logic [39:0] m_data_reg;

    logic [pts_pkg::A_W-1:0] mul_a;
    logic [pts_pkg::P_W-1:0] mul_p;
    pts_pkg::div_req_t       dreq;
    pts_pkg::div_rsp_t       drsp;

    logic        accept;
    logic [2:0]  in_op;
    logic        sdel, ldel;
    logic [32:0] sum_next;
    logic [41:0] total;
    logic [31:0] dly_len;
    logic        dmod_need;
    logic [40:0] seek_end;

    // update path of a plain tick
    logic signed [43:0] bw, ew, pw, sw, rl, up, dn, upd_pos;
    logic               upd_done, upd_dir, upd_pause, upd_ldclr;

    assign in_op  = s_axis_tuser;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign sdel = mode_reg[pts_pkg::F_SDELAY] && (sds_reg < {10'b0, sdlen_reg}) &&
                  ({9'b0, pos_reg} < end_reg);
    assign ldel = mode_reg[pts_pkg::F_LDELAY] && (lds_reg < {10'b0, ldlen_reg}) &&
                  ({9'b0, pos_reg} < end_reg);
    assign sum_next = sdel ? ({1'b0, sde_reg} + 33'(step_reg))
                           : ({1'b0, lde_reg} + 33'(step_reg));
    assign total     = pts_pkg::scale30(mul_p);
    assign dly_len   = sel_ld_reg ? ldlen_reg : sdlen_reg;
    assign dmod_need = (total > 42'(dly_len)) && (dly_len != '0);
    assign seek_end  = mode_reg[pts_pkg::F_RANGE] ? mul_p[40:0] : {9'b0, length_reg};

    always_comb begin
        unique case (state_reg)
            ST_M_BEG:  mul_a = 33'(lstart_reg);
            ST_M_END:  mul_a = 33'(lend_reg);
            ST_M_SD:   mul_a = 33'(sde_reg);
            ST_M_LD:   mul_a = 33'(lde_reg);
            ST_M_STEP: mul_a = 33'(step_reg);
            ST_M_SUM:  mul_a = sum_next;
            ST_SK_MUL: mul_a = 33'(lend_reg);
            default:   mul_a = '0;
        endcase
    end

    // overshoot of a delay wraps modulo its length
    always_comb begin
        dreq.start    = (state_reg == ST_DLY) && dmod_need;
        dreq.dividend = total;
        dreq.divisor  = dly_len;
    end

    always_comb begin
        bw = 44'(beg_reg);
        ew = 44'(end_reg);
        pw = 44'(pos_reg);
        sw = 44'(s_reg);
        rl = ew - bw;
        up = pw + sw;
        dn = pw - sw;
        upd_done  = 1'b0;
        upd_dir   = dir_reg;
        upd_pause = 1'b0;
        upd_ldclr = 1'b0;
        upd_pos   = up;
        if (mode_reg[pts_pkg::F_LINEAR]) begin
            if (mode_reg[pts_pkg::F_REVERSE]) begin
                upd_pos = dn;
                if (dn < bw) begin
                    if (mode_reg[pts_pkg::F_LOOP] && !mode_reg[pts_pkg::F_TRIG]) begin
                        upd_pos   = dn + rl;
                        upd_ldclr = 1'b1;
                    end else begin
                        upd_pos  = bw;
                        upd_done = 1'b1;
                    end
                end
            end else if (up > ew) begin
                if (mode_reg[pts_pkg::F_LOOP] && !mode_reg[pts_pkg::F_TRIG]) begin
                    upd_pos   = up - rl;
                    upd_ldclr = 1'b1;
                end else begin
                    upd_pos  = ew;
                    upd_done = 1'b1;
                end
            end
        end else if (!dir_reg) begin
            if (up > ew) begin
                upd_pause = mode_reg[pts_pkg::F_TRIG];
                upd_dir   = 1'b1;
                upd_pos   = ew - (up - ew);
            end
        end else begin
            upd_pos = dn;
            if (dn < bw) begin
                upd_pause = mode_reg[pts_pkg::F_TRIG];
                upd_dir   = 1'b0;
                upd_pos   = bw;
                upd_ldclr = 1'b1;
            end
        end
    end

    pts_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (scale_reg),
        .p    (mul_p)
    );

    pts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= '0;
            length_reg  <= '0;
            lstart_reg  <= '0;
            lend_reg    <= '0;
            scale_reg   <= 24'd65536;
            sdlen_reg   <= '0;
            ldlen_reg   <= '0;
            pos_reg     <= '0;
            sde_reg     <= '0;
            lde_reg     <= '0;
            run_reg     <= pts_pkg::RUN_STOPPED;
            dir_reg     <= 1'b0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (pts_pkg::reg_idx_t'(cfg_index))
                    pts_pkg::REG_MODE:   mode_reg   <= cfg_data[7:0];
                    pts_pkg::REG_LENGTH: length_reg <= cfg_data;
                    pts_pkg::REG_LSTART: lstart_reg <= cfg_data[15:0];
                    pts_pkg::REG_LEND:   lend_reg   <= cfg_data[15:0];
                    pts_pkg::REG_SCALE:  scale_reg  <= cfg_data[23:0];
                    pts_pkg::REG_SDLEN:  sdlen_reg  <= cfg_data;
                    pts_pkg::REG_LDLEN:  ldlen_reg  <= cfg_data;
                    pts_pkg::REG_UNUSED: ;
                endcase
            end
            if (m_valid_reg && m_axis_tready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        step_reg <= s_axis_tdata[23:0];
                        seek_reg <= s_axis_tdata[55:24];
                        done_reg <= 1'b0;
                        state_reg <= ST_FIN;
                        unique case (pts_pkg::op_t'(in_op))
                            pts_pkg::OP_TICK: begin
                                // linear wins over ping-pong, neither means linear
                                if (mode_reg[pts_pkg::F_LINEAR]) begin
                                    mode_reg[pts_pkg::F_PINGPONG] <= 1'b0;
                                end else if (!mode_reg[pts_pkg::F_PINGPONG]) begin
                                    mode_reg[pts_pkg::F_LINEAR] <= 1'b1;
                                end
                                state_reg <= ST_M_BEG;
                            end
                            pts_pkg::OP_PLAY:  run_reg <= pts_pkg::RUN_PLAYING;
                            pts_pkg::OP_PAUSE: run_reg <= pts_pkg::RUN_PAUSED;
                            pts_pkg::OP_STOP: begin
                                pos_reg <= '0;
                                run_reg <= pts_pkg::RUN_STOPPED;
                            end
                            pts_pkg::OP_SEEK: state_reg <= ST_SK_MUL;
                            pts_pkg::OP_JEND: begin
                                pos_reg <= length_reg;
                                run_reg <= pts_pkg::RUN_PAUSED;
                                dir_reg <= 1'b1;
                            end
                            pts_pkg::OP_JBEGIN: begin
                                pos_reg <= '0;
                                run_reg <= pts_pkg::RUN_PAUSED;
                                dir_reg <= 1'b0;
                            end
                            pts_pkg::OP_NONE: ;
                        endcase
                    end
                end
                ST_M_BEG: state_reg <= ST_M_END;
                ST_M_END: begin
                    beg_reg   <= mode_reg[pts_pkg::F_RANGE] ? mul_p[40:0] : '0;
                    state_reg <= ST_M_SD;
                end
                ST_M_SD: begin
                    end_reg   <= mode_reg[pts_pkg::F_RANGE] ? mul_p[40:0]
                                                            : {9'b0, length_reg};
                    state_reg <= ST_M_LD;
                end
                ST_M_LD: begin
                    sds_reg   <= pts_pkg::scale30(mul_p);
                    state_reg <= ST_M_STEP;
                end
                ST_M_STEP: begin
                    lds_reg   <= pts_pkg::scale30(mul_p);
                    state_reg <= ST_M_SUM;
                end
                ST_M_SUM: begin
                    s_reg      <= pts_pkg::scale30(mul_p);
                    sum_reg    <= sum_next;
                    sel_ld_reg <= !sdel;
                    if (run_reg != pts_pkg::RUN_PLAYING) begin
                        state_reg <= ST_FIN;
                    end else if (sdel || ldel) begin
                        state_reg <= ST_DLY;
                    end else begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_DLY: begin
                    posw_reg <= 44'(pos_reg);
                    if (sel_ld_reg) begin
                        lde_reg <= pts_pkg::div30(sum_reg);
                    end else begin
                        sde_reg <= pts_pkg::div30(sum_reg);
                    end
                    state_reg <= dmod_need ? ST_DMOD : ST_FIN;
                end
                ST_DMOD: begin
                    if (drsp.done) begin
                        pos_reg   <= pts_pkg::sat32(posw_reg + 44'(drsp.remainder));
                        state_reg <= ST_FIN;
                    end
                end
                ST_UPD: begin
                    pos_reg  <= pts_pkg::sat32(upd_pos);
                    done_reg <= upd_done;
                    dir_reg  <= upd_dir;
                    if (upd_pause) begin
                        run_reg <= pts_pkg::RUN_PAUSED;
                    end
                    if (upd_ldclr) begin
                        lde_reg <= '0;
                    end
                    state_reg <= ST_FIN;
                end
                ST_SK_MUL: state_reg <= ST_SK;
                ST_SK: begin
                    lde_reg <= '0;
                    if (mode_reg[pts_pkg::F_PINGPONG] && (41'(seek_reg) > seek_end)) begin
                        dir_reg <= 1'b1;
                        pos_reg <= pts_pkg::sat32(44'({seek_end, 1'b0}) - 44'(seek_reg));
                    end else begin
                        dir_reg <= 1'b0;
                        pos_reg <= seek_reg;
                    end
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {4'b0, dir_reg, run_reg, done_reg, pos_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`include "playback_time_sequencer_assert.svh"

    `PTS_ASSERT_NEXT(a_one_item, aclk, aresetn, accept, !s_axis_tready, "input taken twice in a row")
    `PTS_ASSERT(a_div_in_state, aclk, aresetn, !drsp.busy || state_reg == ST_DMOD, "divider busy outside a delay step")
    `PTS_ASSERT(a_run_code, aclk, aresetn, !m_axis_tvalid || m_axis_tdata[34:33] != 2'd3, "bad run state code")
    `PTS_ASSERT(a_done_playing, aclk, aresetn, !(m_axis_tvalid && m_axis_tdata[32]) || m_axis_tdata[34:33] == pts_pkg::RUN_PLAYING, "done flagged while not playing")

endmodule

// ----- sim/playback_time_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// playback_time_sequencer_tb
// Drives random and directed operation streams into the playback time
// sequencer, predicts position, done, run state and direction per transaction
// and compares every result field against the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module playback_time_sequencer_tb;

    typedef struct packed {
        logic [2:0]  op;
        logic [23:0] step_sec;
        logic [31:0] seek_pos;
    } cmd_t;

    typedef struct packed {
        logic [31:0] position;
        logic        done;
        logic [1:0]  run_state;
        logic        backward;
    } status_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    playback_time_sequencer DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of configuration and state
    logic [7:0]  mdl_flags;
    logic [31:0] mdl_length;
    logic [15:0] mdl_lstart;
    logic [15:0] mdl_lend;
    logic [23:0] mdl_scale;
    logic [31:0] mdl_sdlen;
    logic [31:0] mdl_ldlen;
    logic [31:0] mdl_pos;
    logic [31:0] mdl_sd_elapsed;
    logic [31:0] mdl_ld_elapsed;
    logic [1:0]  mdl_run;
    logic        mdl_back;

    cmd_t    pending_cmds[$];
    status_t expected_status[$];
    int      errors = 0;
    int      cycle_count = 0;
    int      idle_pct_tx;
    int      idle_pct_rx;
    int      rx_holdoff;
    bit      rx_holdoff_req;

    initial begin
        aclk = 1'b0;
    end
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [63:0] frames_of(input logic [63:0] secs);
        logic [127:0] p;
        p = secs * mdl_scale * 30;
        return p[83:20];
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > 66'sh0FFFFFFFF) begin
            r = '1;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [65:0] range_end();
        logic signed [65:0] r;
        if (mdl_flags[pts_pkg::F_RANGE]) r = $signed(66'(mdl_lend) * 66'(mdl_scale));
        else r = $signed({34'b0, mdl_length});
        return r;
    endfunction

    function automatic logic signed [65:0] range_begin();
        logic signed [65:0] r;
        if (mdl_flags[pts_pkg::F_RANGE]) r = $signed(66'(mdl_lstart) * 66'(mdl_scale));
        else r = '0;
        return r;
    endfunction

    // consume a start or loop delay; overshoot wraps modulo the delay length
    task automatic eat_delay(inout logic [31:0] elapsed, input logic [31:0] len,
                             input logic [23:0] step, inout logic signed [65:0] pos);
        logic [63:0] sum;
        logic [63:0] total;
        sum = {32'b0, elapsed} + {40'b0, step};
        total = frames_of(sum);
        if (total > {32'b0, len} && len != 0)
            pos = pos + $signed({2'b0, total % {32'b0, len}});
        elapsed = 32'(sum / 30);
    endtask

    task automatic advance_time(input logic [23:0] step, output logic done);
        logic signed [65:0] b, e, rlen, pos, s;
        logic trig, loop_on, lin, sdel, ldel;
        done = 1'b0;
        if (mdl_flags[pts_pkg::F_LINEAR]) mdl_flags[pts_pkg::F_PINGPONG] = 1'b0;
        else if (!mdl_flags[pts_pkg::F_PINGPONG]) mdl_flags[pts_pkg::F_LINEAR] = 1'b1;
        lin = mdl_flags[pts_pkg::F_LINEAR];
        trig = mdl_flags[pts_pkg::F_TRIG];
        loop_on = mdl_flags[pts_pkg::F_LOOP] && !trig;
        b = range_begin();
        e = range_end();
        rlen = e - b;
        pos = $signed({34'b0, mdl_pos});
        sdel = mdl_flags[pts_pkg::F_SDELAY]
               && frames_of({32'b0, mdl_sd_elapsed}) < {32'b0, mdl_sdlen} && pos < e;
        ldel = mdl_flags[pts_pkg::F_LDELAY]
               && frames_of({32'b0, mdl_ld_elapsed}) < {32'b0, mdl_ldlen} && pos < e;
        if (mdl_run != pts_pkg::RUN_PLAYING) return;
        s = $signed({2'b0, frames_of({40'b0, step})});
        if (sdel) begin
            eat_delay(mdl_sd_elapsed, mdl_sdlen, step, pos);
        end else if (ldel) begin
            eat_delay(mdl_ld_elapsed, mdl_ldlen, step, pos);
        end else if (lin) begin
            if (mdl_flags[pts_pkg::F_REVERSE]) begin
                pos = pos - s;
                if (pos < b) begin
                    if (loop_on) begin
                        pos = pos + rlen;
                        mdl_ld_elapsed = '0;
                    end else begin
                        pos = b;
                        done = 1'b1;
                    end
                end
            end else begin
                pos = pos + s;
                if (pos > e) begin
                    if (loop_on) begin
                        pos = pos - rlen;
                        mdl_ld_elapsed = '0;
                    end else begin
                        pos = e;
                        done = 1'b1;
                    end
                end
            end
        end else if (!mdl_back) begin
            pos = pos + s;
            if (pos > e) begin
                if (trig) mdl_run = pts_pkg::RUN_PAUSED;
                mdl_back = 1'b1;
                pos = e - (pos - e);
            end
        end else begin
            pos = pos - s;
            if (pos < b) begin
                if (trig) mdl_run = pts_pkg::RUN_PAUSED;
                mdl_back = 1'b0;
                pos = b;
                mdl_ld_elapsed = '0;
            end
        end
        mdl_pos = clamp32(pos);
    endtask

    task automatic predict_status(input cmd_t c);
        status_t r;
        logic d;
        logic signed [65:0] e;
        d = 1'b0;
        case (pts_pkg::op_t'(c.op))
            pts_pkg::OP_TICK: begin
                advance_time(c.step_sec, d);
            end
            pts_pkg::OP_PLAY: begin
                mdl_run = pts_pkg::RUN_PLAYING;
            end
            pts_pkg::OP_PAUSE: begin
                mdl_run = pts_pkg::RUN_PAUSED;
            end
            pts_pkg::OP_STOP: begin
                mdl_pos = '0;
                mdl_run = pts_pkg::RUN_STOPPED;
            end
            pts_pkg::OP_SEEK: begin
                mdl_pos = c.seek_pos;
                mdl_back = 1'b0;
                mdl_ld_elapsed = '0;
                if (mdl_flags[pts_pkg::F_PINGPONG]) begin
                    e = range_end();
                    if ($signed({34'b0, c.seek_pos}) > e) begin
                        mdl_back = 1'b1;
                        mdl_pos = clamp32(e - ($signed({34'b0, c.seek_pos}) - e));
                    end
                end
            end
            pts_pkg::OP_JEND: begin
                mdl_pos = mdl_length;
                mdl_run = pts_pkg::RUN_PAUSED;
                mdl_back = 1'b1;
            end
            pts_pkg::OP_JBEGIN: begin
                mdl_pos = '0;
                mdl_run = pts_pkg::RUN_PAUSED;
                mdl_back = 1'b0;
            end
            default: begin
            end
        endcase
        r.position = mdl_pos;
        r.done = d;
        r.run_state = mdl_run;
        r.backward = mdl_back;
        expected_status.push_back(r);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct_tx) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_cmds[0].op;
                s_axis_tdata <= {pending_cmds[0].seek_pos, pending_cmds[0].step_sec};
                void'(pending_cmds.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // predict on accepted transactions
    always @(posedge aclk) begin
        cmd_t c;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            c.op = s_axis_tuser;
            c.step_sec = s_axis_tdata[23:0];
            c.seek_pos = s_axis_tdata[55:24];
            predict_status(c);
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        status_t got, want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_holdoff <= 0;
        end else begin
            if (rx_holdoff_req && rx_holdoff == 0) rx_holdoff <= 400;
            else if (rx_holdoff > 0) rx_holdoff <= rx_holdoff - 1;
            m_axis_tready <= (rx_holdoff <= 1) && ($urandom_range(99) >= idle_pct_rx);
            if (m_axis_tvalid && m_axis_tready) begin
                got.position = m_axis_tdata[31:0];
                got.done = m_axis_tdata[32];
                got.run_state = m_axis_tdata[34:33];
                got.backward = m_axis_tdata[35];
                if (expected_status.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = expected_status.pop_front();
                    if (got.position !== want.position) begin
                        $display("%0t: position expected %h actual %h", $time,
                                 want.position, got.position);
                        errors++;
                    end
                    if (got.done !== want.done) begin
                        $display("%0t: done expected %b actual %b", $time,
                                 want.done, got.done);
                        errors++;
                    end
                    if (got.run_state !== want.run_state) begin
                        $display("%0t: run_state expected %0d actual %0d", $time,
                                 want.run_state, got.run_state);
                        errors++;
                    end
                    if (got.backward !== want.backward) begin
                        $display("%0t: direction expected %b actual %b", $time,
                                 want.backward, got.backward);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input pts_pkg::reg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            pts_pkg::REG_MODE:   mdl_flags = val[7:0];
            pts_pkg::REG_LENGTH: mdl_length = val;
            pts_pkg::REG_LSTART: mdl_lstart = val[15:0];
            pts_pkg::REG_LEND:   mdl_lend = val[15:0];
            pts_pkg::REG_SCALE:  mdl_scale = val[23:0];
            pts_pkg::REG_SDLEN:  mdl_sdlen = val;
            pts_pkg::REG_LDLEN:  mdl_ldlen = val;
            default: begin
            end
        endcase
    endtask

    task automatic queue_cmd(input pts_pkg::op_t op, input logic [23:0] st,
                             input logic [31:0] sk);
        cmd_t c;
        c.op = op;
        c.step_sec = st;
        c.seek_pos = sk;
        pending_cmds.push_back(c);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_status.size() > 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_step();
        logic [23:0] r;
        case ($urandom_range(3))
            0: r = 24'($urandom_range(0, 4096));
            1: r = 24'($urandom_range(0, 65536));
            2: r = 24'($urandom);
            default: r = ($urandom_range(1)) ? 24'hFFFFFF : 24'h0;
        endcase
        return r;
    endfunction

    task automatic random_config();
        write_reg(pts_pkg::REG_MODE, 32'($urandom_range(255)));
        write_reg(pts_pkg::REG_LENGTH, ($urandom_range(3) == 0) ? $urandom
                                       : 32'($urandom_range(1, 200)) << 16);
        write_reg(pts_pkg::REG_LSTART, 32'($urandom_range(0, 60)));
        write_reg(pts_pkg::REG_LEND, ($urandom_range(7) == 0) ? 32'($urandom_range(65535))
                                     : 32'($urandom_range(0, 120)));
        write_reg(pts_pkg::REG_SCALE, ($urandom_range(5) == 0)
                                      ? 32'($urandom_range(24'hFFFFFF))
                                      : 32'($urandom_range(16384, 131072)));
        write_reg(pts_pkg::REG_SDLEN, ($urandom_range(3) == 0) ? $urandom
                                      : 32'($urandom_range(0, 20)) << 16);
        write_reg(pts_pkg::REG_LDLEN, ($urandom_range(3) == 0) ? $urandom
                                      : 32'($urandom_range(0, 20)) << 16);
    endtask

    initial begin
        int n;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct_tx = 33;
        idle_pct_rx = 33;
        rx_holdoff_req = 1'b0;
        mdl_flags = '0; mdl_length = '0; mdl_lstart = '0; mdl_lend = '0;
        mdl_scale = 24'd65536; mdl_sdlen = '0; mdl_ldlen = '0;
        mdl_pos = '0; mdl_sd_elapsed = '0; mdl_ld_elapsed = '0;
        mdl_run = pts_pkg::RUN_STOPPED; mdl_back = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every op at defaults, extremes of fields
        queue_cmd(pts_pkg::OP_TICK, 24'hFFFFFF, 32'hFFFFFFFF);
        queue_cmd(pts_pkg::OP_PLAY, '0, '0);
        queue_cmd(pts_pkg::OP_TICK, 24'h100000, '0);
        queue_cmd(pts_pkg::OP_SEEK, '0, 32'hFFFFFFFF);
        queue_cmd(pts_pkg::OP_NONE, 24'hFFFFFF, 32'hFFFFFFFF);
        queue_cmd(pts_pkg::OP_PAUSE, '0, '0);
        queue_cmd(pts_pkg::OP_JEND, '0, '0);
        queue_cmd(pts_pkg::OP_JBEGIN, '0, '0);
        queue_cmd(pts_pkg::OP_STOP, '0, '0);
        drain();
        // ping-pong, triggered, max scale; seek reflects past end
        write_reg(pts_pkg::REG_MODE, 32'h42);
        write_reg(pts_pkg::REG_LENGTH, 32'h000A0000);
        write_reg(pts_pkg::REG_SCALE, 32'hFFFFFF);
        queue_cmd(pts_pkg::OP_SEEK, '0, 32'h000F0000);
        queue_cmd(pts_pkg::OP_PLAY, '0, '0);
        queue_cmd(pts_pkg::OP_TICK, 24'h000400, '0);
        queue_cmd(pts_pkg::OP_TICK, 24'hFFFFFF, '0);
        queue_cmd(pts_pkg::OP_PLAY, '0, '0);
        queue_cmd(pts_pkg::OP_TICK, 24'hFFFFFF, '0);
        drain();
        // reversed range, reverse linear loop, delays
        write_reg(pts_pkg::REG_MODE, 32'hBD);
        write_reg(pts_pkg::REG_LSTART, 32'hFFFF);
        write_reg(pts_pkg::REG_LEND, 32'h0003);
        write_reg(pts_pkg::REG_SCALE, 32'h0);
        write_reg(pts_pkg::REG_SDLEN, 32'hFFFFFFFF);
        write_reg(pts_pkg::REG_LDLEN, 32'h00030000);
        queue_cmd(pts_pkg::OP_PLAY, '0, '0);
        queue_cmd(pts_pkg::OP_TICK, 24'h080000, '0);
        drain();
        write_reg(pts_pkg::REG_SCALE, 32'h10000);
        queue_cmd(pts_pkg::OP_TICK, 24'h080000, '0);
        queue_cmd(pts_pkg::OP_SEEK, '0, 32'h00020000);
        queue_cmd(pts_pkg::OP_TICK, 24'hFFFFFF, '0);
        drain();
        write_reg(pts_pkg::REG_SDLEN, 32'h0);

        // random phases with well formed play sequences
        for (int ph = 0; ph < 14; ph++) begin
            random_config();
            idle_pct_tx = (ph == 3) ? 0 : 33;
            idle_pct_rx = (ph == 3) ? 0 : 33;
            rx_holdoff_req = (ph == 5);
            queue_cmd(pts_pkg::OP_SEEK, '0, ($urandom_range(3) == 0) ? $urandom
                                            : 32'($urandom_range(0, 100)) << 16);
            queue_cmd(pts_pkg::OP_PLAY, '0, '0);
            n = 0;
            while (n < 58) begin
                if ($urandom_range(9) < 7) begin
                    queue_cmd(pts_pkg::OP_TICK, rand_step(), $urandom);
                end else begin
                    queue_cmd(pts_pkg::op_t'($urandom_range(7)), rand_step(), $urandom);
                end
                n++;
            end
            if (ph == 5) begin
                repeat (20) @(posedge aclk);
                rx_holdoff_req = 1'b0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
